FILE: rtl/core/segtr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segtr_pkg
// Shared widths, codes and state encoding for the range-sum tree block.
// ----------------------------------------------------------------------------
package segtr_pkg;

  localparam int unsigned CMD_W          = 2;
  localparam int unsigned POS_W          = 15;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned COUNT_W        = 15;
  localparam int unsigned PADDR_W        = 2;
  localparam int unsigned PDATA_W        = 32;
  localparam int unsigned LEAF_COUNT_DEF = 16384;
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(16384);
  localparam logic [PADDR_W-1:0] ADDR_ELEMENT_COUNT = PADDR_W'(0);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_SUB   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_Q_HEAD,
    ST_Q_ACC_L,
    ST_Q_ACC_R,
    ST_DONE
  } state_e;

  typedef logic [CMD_W-1:0]         cmd_t;
  typedef logic [POS_W-1:0]         pos_t;
  typedef logic signed [DATA_W-1:0] data_t;

endpackage
`default_nettype wire

FILE: rtl/core/segtr_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segtr_cmd_if
// Command channel: valid/ready handshake with one command beat.
// ----------------------------------------------------------------------------
interface segtr_cmd_if;
  import segtr_pkg::*;

  logic  valid;
  logic  ready;
  cmd_t  cmd;
  pos_t  position;
  pos_t  right_bound;
  data_t amount;

  modport source (output valid, output cmd, output position, output right_bound,
                  output amount, input ready);
  modport sink   (input valid, input cmd, input position, input right_bound,
                  input amount, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/segtr_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segtr_res_if
// Result channel: valid/ready handshake with one result beat.
// ----------------------------------------------------------------------------
interface segtr_res_if;
  import segtr_pkg::*;

  logic  valid;
  logic  ready;
  data_t range_sum;
  logic  bad_position;

  modport source (output valid, output range_sum, output bad_position, input ready);
  modport sink   (input valid, input range_sum, input bad_position, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/segment_tree_point_update_range_sum.sv
`timescale 1ns / 1ps
`default_nettype none
// Add/subtract: one read and one write per node, from the leaf up to the root.
// Query: both bounds climb one tree level at a time, adding at most one left and one right node per level.
// Bad position or unused command: no tree walk. One command in flight; result is registered.
// Throughput is bound by the single read port of the node memory and the shared adder.
// After reset all 2*LEAF_COUNT node words are cleared, with cmd ready low.
// APB writes are taken at any time; element_count resets to 16384.
// ----------------------------------------------------------------------------
// segment_tree_point_update_range_sum
// Bottom-up binary sum tree with point add/subtract and inclusive range-sum
// queries, walked by a small sequencer around one shared adder.
// ----------------------------------------------------------------------------
module segment_tree_point_update_range_sum #(
  parameter int unsigned LEAF_COUNT = segtr_pkg::LEAF_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  segtr_cmd_if.sink                      cmd_i,
  segtr_res_if.source                    res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [segtr_pkg::PADDR_W-1:0]  paddr,
  input  logic [segtr_pkg::PDATA_W-1:0]  pwdata,
  output logic [segtr_pkg::PDATA_W-1:0]  prdata,
  output logic                           pready
);
  import segtr_pkg::*;

  localparam int unsigned DEPTH = 2 * LEAF_COUNT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned IW    = AW + 1;
  localparam int unsigned WW    = (IW > POS_W) ? IW : POS_W;

  state_e            state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [AW-1:0]     node_q, node_d;
  logic [IW-1:0]     l_q, l_d, r_q, r_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] amt_q, amt_d;
  logic              sub_q, sub_d;
  logic              bad_q, bad_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_sum_q, out_sum_d;
  logic              out_bad_q, out_bad_d;
  logic [COUNT_W-1:0] count_q;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  logic [DATA_W-1:0] add_b, add_sum;
  logic              add_sub;

  logic [WW-1:0]     cnt_ext, act_cnt, pos_ext, rb_ext, leaf_w, rend_w;
  logic              p_ok, rb_ok;
  logic [IW-1:0]     l_start, r_start, l_inc, r_dec;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ELEMENT_COUNT) ? PDATA_W'(count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (psel && penable && pwrite) begin
      count_q <= pwdata[COUNT_W-1:0];
    end
  end

  // position checks and start indices
  assign cnt_ext = WW'(count_q);
  assign act_cnt = (cnt_ext > WW'(LEAF_COUNT)) ? WW'(LEAF_COUNT) : cnt_ext;
  assign pos_ext = WW'(cmd_i.position);
  assign rb_ext  = WW'(cmd_i.right_bound);
  assign p_ok    = (pos_ext != '0) && (pos_ext <= act_cnt);
  assign rb_ok   = (rb_ext != '0) && (rb_ext <= act_cnt);
  assign leaf_w  = WW'(LEAF_COUNT) + pos_ext - WW'(1);
  assign rend_w  = WW'(LEAF_COUNT) + rb_ext;
  assign l_start = leaf_w[IW-1:0];
  assign r_start = rend_w[IW-1:0];
  assign l_inc   = l_q + IW'(1);
  assign r_dec   = r_q - IW'(1);

  // shared adder
  assign add_sum = mem_rdata + (add_sub ? ~add_b : add_b) + DATA_W'(add_sub);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q    <= node_d;
    l_q       <= l_d;
    r_q       <= r_d;
    acc_q     <= acc_d;
    amt_q     <= amt_d;
    sub_q     <= sub_d;
    bad_q     <= bad_d;
    out_sum_q <= out_sum_d;
    out_bad_q <= out_bad_d;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    node_d      = node_q;
    l_d         = l_q;
    r_d         = r_q;
    acc_d       = acc_q;
    amt_d       = amt_q;
    sub_d       = sub_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q & ~res_o.ready;
    out_sum_d   = out_sum_q;
    out_bad_d   = out_bad_q;
    mem_we      = 1'b0;
    mem_waddr   = node_q;
    mem_wdata   = add_sum;
    mem_re      = 1'b0;
    mem_raddr   = node_q;
    add_b       = acc_q;
    add_sub     = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_i.valid) begin
          acc_d  = '0;
          amt_d  = cmd_i.amount;
          sub_d  = (cmd_i.cmd == CMD_SUB);
          bad_d  = 1'b0;
          l_d    = l_start;
          r_d    = r_start;
          node_d = l_start[AW-1:0];
          if (cmd_i.cmd == CMD_ADD || cmd_i.cmd == CMD_SUB) begin
            if (p_ok) begin
              state_d = ST_UPD_RD;
            end else begin
              bad_d   = 1'b1;
              state_d = ST_DONE;
            end
          end else if (cmd_i.cmd == CMD_QUERY) begin
            if (p_ok && rb_ok) begin
              state_d = ST_Q_HEAD;
            end else begin
              bad_d   = 1'b1;
              state_d = ST_DONE;
            end
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_UPD_RD: begin
        mem_re  = 1'b1;
        state_d = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        // write this node, fetch its parent in the same cycle
        add_b   = amt_q;
        add_sub = sub_q;
        mem_we  = 1'b1;
        if (node_q == AW'(1)) begin
          state_d = ST_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = node_q >> 1;
          node_d    = node_q >> 1;
        end
      end
      ST_Q_HEAD: begin
        if (l_q >= r_q) begin
          state_d = ST_DONE;
        end else if (l_q[0]) begin
          mem_re    = 1'b1;
          mem_raddr = l_q[AW-1:0];
          state_d   = ST_Q_ACC_L;
        end else if (r_q[0]) begin
          mem_re    = 1'b1;
          mem_raddr = r_dec[AW-1:0];
          state_d   = ST_Q_ACC_R;
        end else begin
          l_d = l_q >> 1;
          r_d = r_q >> 1;
        end
      end
      ST_Q_ACC_L: begin
        acc_d = add_sum;
        if (r_q[0]) begin
          mem_re    = 1'b1;
          mem_raddr = r_dec[AW-1:0];
          l_d       = l_inc;
          state_d   = ST_Q_ACC_R;
        end else begin
          l_d     = l_inc >> 1;
          r_d     = r_q >> 1;
          state_d = ST_Q_HEAD;
        end
      end
      ST_Q_ACC_R: begin
        acc_d   = add_sum;
        l_d     = l_q >> 1;
        r_d     = r_q >> 1;
        state_d = ST_Q_HEAD;
      end
      ST_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_sum_d   = acc_q;
          out_bad_d   = bad_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign cmd_i.ready        = (state_q == ST_IDLE);
  assign res_o.valid        = out_valid_q;
  assign res_o.range_sum    = out_sum_q;
  assign res_o.bad_position = out_bad_q;

  segtr_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // node 0 is never a tree node
  a_upd_addr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q != ST_CLEAR) |-> mem_waddr != '0)
    else $error("tree write to node 0");

  a_rw_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> mem_waddr != mem_raddr)
    else $error("read and write hit the same node");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result beat raised outside of completion");

  a_bad_no_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && cmd_i.valid && !p_ok) |=> state_q == ST_DONE)
    else $error("bad position started a tree walk");

endmodule
`default_nettype wire

FILE: rtl/core/segtr_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segtr_mem
// Node sum storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module segtr_mem #(
  parameter int unsigned DEPTH = 2 * segtr_pkg::LEAF_COUNT_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AW-1:0]                  waddr_i,
  input  logic [segtr_pkg::DATA_W-1:0]   wdata_i,
  input  logic                           re_i,
  input  logic [AW-1:0]                  raddr_i,
  output logic [segtr_pkg::DATA_W-1:0]   rdata_o
);
  import segtr_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: bench/tb_segment_tree_point_update_range_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_tree_point_update_range_sum
// Self-checking bench for the range-sum tree. Commands stream through the
// command channel while a flat array of counters predicts every result beat.
// Directed corners come first: extreme positions and amounts, empty and
// out-of-range queries, zero, unit and oversized element counts, and the
// unused command. Randomized phases follow at several element counts, with
// bursty stalls on both channels, one long result hold-off and one drain pause.
// ----------------------------------------------------------------------------
module tb_segment_tree_point_update_range_sum;
  import segtr_pkg::*;

  localparam int unsigned LEAFS       = LEAF_COUNT_DEF;
  localparam int unsigned POS_MAX     = (1 << POS_W) - 1;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned LONG_HOLD   = 300;
  localparam cmd_t        CMD_UNUSED  = 2'd3;

  typedef struct packed {
    cmd_t  cmd;
    pos_t  position;
    pos_t  right_bound;
    data_t amount;
  } tree_cmd_t;

  typedef struct packed {
    data_t range_sum;
    logic  bad_position;
  } tree_res_t;

  logic clk;
  logic rst_n;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  segtr_cmd_if cmd_if ();
  segtr_res_if res_if ();

  segment_tree_point_update_range_sum i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cmd_i   (cmd_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [DATA_W-1:0]  leaf_vals [1:LEAFS];
  logic [COUNT_W-1:0] count_model;

  tree_cmd_t cmd_backlog [$];
  tree_res_t owed_results [$];
  tree_cmd_t offered_cmd;

  int unsigned queued_total;
  int unsigned accepted_total;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned send_wait;
  int unsigned sink_wait;
  bit          beat_taken;
  bit          idle_on;
  bit          send_pause;
  bit          long_hold_req;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic tree_res_t run_tree_command(tree_cmd_t c);
    tree_res_t         r;
    int unsigned       live;
    int unsigned       lo;
    int unsigned       hi;
    int unsigned       k;
    logic [DATA_W-1:0] acc;
    r.range_sum    = '0;
    r.bad_position = 1'b0;
    live = (count_model > LEAFS) ? LEAFS : count_model;
    lo   = c.position;
    hi   = c.right_bound;
    case (c.cmd)
      CMD_ADD, CMD_SUB: begin
        if (lo >= 1 && lo <= live) begin
          if (c.cmd == CMD_ADD) leaf_vals[lo] = leaf_vals[lo] + c.amount;
          else                  leaf_vals[lo] = leaf_vals[lo] - c.amount;
        end else begin
          r.bad_position = 1'b1;
        end
      end
      CMD_QUERY: begin
        if (lo < 1 || lo > live || hi < 1 || hi > live) begin
          r.bad_position = 1'b1;
        end else if (lo <= hi) begin
          acc = '0;
          for (k = lo; k <= hi; k++) acc = acc + leaf_vals[k];
          r.range_sum = acc;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic tree_cmd_t mk_cmd(cmd_t op, int unsigned p, int unsigned rb,
                                       logic [DATA_W-1:0] amt);
    tree_cmd_t c;
    c.cmd         = op;
    c.position    = pos_t'(p);
    c.right_bound = pos_t'(rb);
    c.amount      = amt;
    return c;
  endfunction

  function automatic logic [DATA_W-1:0] rand_amount();
    case ($urandom_range(0, 5))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return DATA_W'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned rand_bad_pos(int unsigned live);
    if ($urandom_range(0, 3) == 0 || live >= POS_MAX) return 0;
    return $urandom_range(live + 1, POS_MAX);
  endfunction

  function automatic tree_cmd_t rand_cmd();
    int unsigned live;
    int unsigned lo;
    int unsigned hi;
    int unsigned t;
    int unsigned kind;
    live = (count_model > LEAFS) ? LEAFS : count_model;
    kind = $urandom_range(0, 99);
    if (live == 0 && kind < 80) kind = 80;
    if (kind < 40) begin
      return mk_cmd($urandom_range(0, 1) ? CMD_ADD : CMD_SUB, $urandom_range(1, live),
                    $urandom_range(0, POS_MAX), rand_amount());
    end else if (kind < 80) begin
      lo = $urandom_range(1, live);
      if ($urandom_range(0, 1)) hi = $urandom_range(1, live);
      else hi = (lo + $urandom_range(0, 20) > live) ? live : lo + $urandom_range(0, 20);
      if (lo > hi && $urandom_range(0, 3) != 0) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
      return mk_cmd(CMD_QUERY, lo, hi, $urandom);
    end else if (kind < 90) begin
      case ($urandom_range(0, 2))
        0:       return mk_cmd(CMD_ADD, rand_bad_pos(live), $urandom_range(0, POS_MAX),
                               rand_amount());
        1:       return mk_cmd(CMD_QUERY, rand_bad_pos(live), $urandom_range(0, POS_MAX),
                               $urandom);
        default: return mk_cmd(CMD_QUERY, (live == 0) ? 1 : $urandom_range(1, live),
                               rand_bad_pos(live), $urandom);
      endcase
    end
    return mk_cmd(cmd_t'($urandom_range(0, 3)), $urandom_range(0, POS_MAX),
                  $urandom_range(0, POS_MAX), $urandom);
  endfunction

  task automatic queue_cmd(input tree_cmd_t c);
    cmd_backlog.push_back(c);
    queued_total++;
  endtask

  task automatic queue_random(input int unsigned n);
    repeat (n) queue_cmd(rand_cmd());
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (accepted_total != queued_total || owed_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input int unsigned val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ELEMENT_COUNT;
    pwdata  <= PDATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    count_model = COUNT_W'(val);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PDATA_W'(count_model)) begin
      $error("element_count readback: expected %0d, got %0d", count_model, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // command driver
  always @(posedge clk) begin
    if (rst_n && cmd_if.valid && cmd_if.ready) begin
      owed_results.push_back(run_tree_command(offered_cmd));
      accepted_total++;
      beat_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!cmd_if.valid || beat_taken) begin
      beat_taken = 1'b0;
      if (send_wait > 0) begin
        send_wait--;
        cmd_if.valid <= 1'b0;
      end else if (rst_n && !send_pause && cmd_backlog.size() > 0) begin
        offered_cmd = cmd_backlog.pop_front();
        cmd_if.cmd         <= offered_cmd.cmd;
        cmd_if.position    <= offered_cmd.position;
        cmd_if.right_bound <= offered_cmd.right_bound;
        cmd_if.amount      <= offered_cmd.amount;
        cmd_if.valid       <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) send_wait = $urandom_range(1, 19);
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      sink_wait     = LONG_HOLD;
    end
    if (sink_wait > 0) begin
      sink_wait--;
      res_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      sink_wait = $urandom_range(1, 19) - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tree_res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (owed_results.size() == 0) begin
        $error("unexpected result beat: range_sum %0d, bad_position %0b",
               res_if.range_sum, res_if.bad_position);
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        if (res_if.range_sum !== want.range_sum) begin
          $error("range_sum: expected %0d, got %0d", want.range_sum, res_if.range_sum);
          fail_count++;
        end
        if (res_if.bad_position !== want.bad_position) begin
          $error("bad_position: expected %0b, got %0b", want.bad_position,
                 res_if.bad_position);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned mark;
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    cmd_if.valid       = 1'b0;
    cmd_if.cmd         = CMD_ADD;
    cmd_if.position    = '0;
    cmd_if.right_bound = '0;
    cmd_if.amount      = '0;
    res_if.ready       = 1'b0;
    queued_total       = 0;
    accepted_total     = 0;
    fail_count         = 0;
    cycle_count        = 0;
    send_wait          = 0;
    sink_wait          = 0;
    beat_taken         = 1'b0;
    send_pause         = 1'b0;
    long_hold_req      = 1'b0;
    idle_on            = 1'b1;
    count_model        = COUNT_RESET;
    for (int unsigned i = 1; i <= LEAFS; i++) leaf_vals[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // corners at the reset element count
    queue_cmd(mk_cmd(CMD_QUERY, 1, LEAFS, 0));
    queue_cmd(mk_cmd(CMD_ADD, 1, 0, 32'h7fff_ffff));
    queue_cmd(mk_cmd(CMD_ADD, LEAFS, POS_MAX, 32'h8000_0000));
    queue_cmd(mk_cmd(CMD_SUB, 2, 0, 32'hffff_ffff));
    queue_cmd(mk_cmd(CMD_ADD, 8191, 0, 32'h5555_5555));
    queue_cmd(mk_cmd(CMD_SUB, LEAFS, 0, 32'h8000_0000));
    queue_cmd(mk_cmd(CMD_ADD, 3, 0, 32'h7fff_ffff));
    queue_cmd(mk_cmd(CMD_QUERY, 1, LEAFS, 32'hffff_ffff));
    queue_cmd(mk_cmd(CMD_QUERY, 1, 1, 0));
    queue_cmd(mk_cmd(CMD_QUERY, LEAFS, LEAFS, 0));
    queue_cmd(mk_cmd(CMD_QUERY, 5, 3, 0));
    queue_cmd(mk_cmd(CMD_QUERY, LEAFS, 1, 0));
    queue_cmd(mk_cmd(CMD_QUERY, 0, 5, 0));
    queue_cmd(mk_cmd(CMD_QUERY, 3, LEAFS + 1, 0));
    queue_cmd(mk_cmd(CMD_QUERY, POS_MAX, POS_MAX, 0));
    queue_cmd(mk_cmd(CMD_ADD, 0, 0, 32'h1234_5678));
    queue_cmd(mk_cmd(CMD_SUB, POS_MAX, POS_MAX, 32'hffff_ffff));
    queue_cmd(mk_cmd(CMD_UNUSED, 4, 9, 32'hdead_beef));
    queue_cmd(mk_cmd(CMD_QUERY, 2, 8191, 0));
    wait_drained();

    // zero, unit and oversized counts
    write_count(0);
    queue_cmd(mk_cmd(CMD_ADD, 1, 0, 32'd7));
    queue_cmd(mk_cmd(CMD_QUERY, 1, 1, 0));
    queue_cmd(mk_cmd(CMD_SUB, 5, 0, 32'd7));
    wait_drained();
    write_count(1);
    queue_cmd(mk_cmd(CMD_ADD, 1, 0, 32'd100));
    queue_cmd(mk_cmd(CMD_QUERY, 1, 1, 0));
    queue_cmd(mk_cmd(CMD_ADD, 2, 0, 32'd5));
    queue_cmd(mk_cmd(CMD_QUERY, 1, 2, 0));
    wait_drained();
    write_count(POS_MAX);
    queue_cmd(mk_cmd(CMD_QUERY, 1, LEAFS, 0));
    queue_cmd(mk_cmd(CMD_QUERY, LEAFS, LEAFS, 0));
    queue_cmd(mk_cmd(CMD_ADD, LEAFS + 1, 0, 32'd1));
    wait_drained();

    // short array, with a drain pause partway through
    write_count(37);
    mark = accepted_total + 40;
    queue_random(120);
    do @(negedge clk); while (accepted_total < mark);
    @(posedge clk);
    send_pause = 1'b1;
    do @(negedge clk); while (cmd_if.valid || owed_results.size() != 0);
    @(posedge clk);
    send_pause = 1'b0;
    wait_drained();

    // full array, result side held off at the start
    write_count(LEAFS);
    long_hold_req = 1'b1;
    queue_random(100);
    wait_drained();

    idle_on = 1'b0;
    write_count(2);
    queue_random(30);
    wait_drained();

    idle_on = 1'b1;
    write_count(20000);
    queue_random(60);
    wait_drained();

    idle_on = 1'b0;
    write_count(LEAFS - 1);
    queue_random(60);
    wait_drained();

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
